>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/wmcc_pkg.sv
// ----------------------------------------------------------------------------
// wmcc_pkg
// constants, types and controller/datapath interface for the crossing counter
// ----------------------------------------------------------------------------
package wmcc_pkg;

	localparam int WINDOW       = 50;
	localparam int SAMPLE_BITS  = 14;
	localparam int THRESH_BITS  = 13;
	localparam int COUNT_BITS   = 10;
	localparam int ADDR_BITS    = $clog2(WINDOW);
	localparam int SUM_BITS     = SAMPLE_BITS + ADDR_BITS;
	localparam int CNT_BITS     = ADDR_BITS;
	localparam int DIFF_BITS    = SAMPLE_BITS + 2;
	localparam int RECIP_SHIFT  = SUM_BITS - 1 + ADDR_BITS;

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(95);
	localparam logic [CNT_BITS-1:0]    CNT_WIN_LAST = CNT_BITS'(WINDOW - 1);
	// rounded-up reciprocal of the window length, exact for every sum magnitude
	localparam logic [SUM_BITS-1:0]    RECIP        = SUM_BITS'(
		((longint'(1) << RECIP_SHIFT) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW));

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]         count_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIV,
		ST_MEAN,
		ST_WALK,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic mean_latch;
		logic walk_rd;
		logic out_load;
		logic cnt_clr;
		logic cnt_inc;
	} cmd_t;

	typedef struct packed {
		logic cnt_last_win;
	} sts_t;

endpackage

>>> sv/wmcc_ctrl.sv
// ----------------------------------------------------------------------------
// wmcc_ctrl
// sequencer: load window, divide, walk stored pairs, hand off result
// ----------------------------------------------------------------------------
module wmcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  wmcc_pkg::sts_t    sts,
	output wmcc_pkg::cmd_t    cmd
);

	wmcc_pkg::state_t state_q;
	wmcc_pkg::state_t state_nxt;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wmcc_pkg::ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			wmcc_pkg::ST_LOAD: begin
				if (in_valid && sts.cnt_last_win) begin
					state_nxt = wmcc_pkg::ST_DIV;
				end
			end
			wmcc_pkg::ST_DIV: begin
				state_nxt = wmcc_pkg::ST_MEAN;
			end
			wmcc_pkg::ST_MEAN: begin
				state_nxt = wmcc_pkg::ST_WALK;
			end
			wmcc_pkg::ST_WALK: begin
				if (sts.cnt_last_win) begin
					state_nxt = wmcc_pkg::ST_DRAIN;
				end
			end
			wmcc_pkg::ST_DRAIN: begin
				state_nxt = wmcc_pkg::ST_OUT;
			end
			wmcc_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = wmcc_pkg::ST_LOAD;
				end
			end
			default: begin
				state_nxt = wmcc_pkg::ST_LOAD;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			wmcc_pkg::ST_LOAD: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				cmd.cnt_clr = in_valid && sts.cnt_last_win;
				cmd.cnt_inc = in_valid && !sts.cnt_last_win;
			end
			wmcc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			wmcc_pkg::ST_MEAN: begin
				cmd.mean_latch = 1'b1;
			end
			wmcc_pkg::ST_WALK: begin
				cmd.walk_rd = 1'b1;
				cmd.cnt_clr = sts.cnt_last_win;
				cmd.cnt_inc = !sts.cnt_last_win;
			end
			wmcc_pkg::ST_DRAIN: begin
				cmd = '0;
			end
			wmcc_pkg::ST_OUT: begin
				cmd.out_load = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/wmcc_dp.sv
// ----------------------------------------------------------------------------
// wmcc_dp
// sample stores, running sums, reciprocal divide by the window length,
// crossing walk and result registers
// ----------------------------------------------------------------------------
module wmcc_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  wmcc_pkg::cmd_t                          cmd,
	output wmcc_pkg::sts_t                          sts,
	input  logic                                    cfg_write_en,
	input  logic [wmcc_pkg::THRESH_BITS-1:0]        cfg_write_data,
	input  logic signed [wmcc_pkg::SAMPLE_BITS-1:0] sample_y,
	input  logic signed [wmcc_pkg::SAMPLE_BITS-1:0] sample_z,
	output logic signed [wmcc_pkg::SAMPLE_BITS-1:0] mean_y,
	output logic signed [wmcc_pkg::SAMPLE_BITS-1:0] mean_z,
	output logic [wmcc_pkg::COUNT_BITS-1:0]         crossings_y,
	output logic [wmcc_pkg::COUNT_BITS-1:0]         crossings_z
);

	localparam int SB = wmcc_pkg::SAMPLE_BITS;
	localparam int SM = wmcc_pkg::SUM_BITS;
	localparam int AB = wmcc_pkg::ADDR_BITS;
	localparam int DB = wmcc_pkg::DIFF_BITS;
	localparam int TB = wmcc_pkg::THRESH_BITS;

	// sample stores
	wmcc_pkg::sample_t mem_y [wmcc_pkg::WINDOW];
	wmcc_pkg::sample_t mem_z [wmcc_pkg::WINDOW];

	logic [wmcc_pkg::CNT_BITS-1:0] cnt_q;
	logic [AB-1:0]                 addr;
	logic [TB-1:0]                 thr_q;

	logic signed [SM-1:0] sum_y_q, sum_z_q;
	logic signed [SM-1:0] sum_y_nxt, sum_z_nxt;

	logic [SM-1:0]   mag_y_q, mag_z_q;
	logic [SB-1:0]   quo_y_q, quo_z_q;
	logic            neg_y_q, neg_z_q;
	logic [2*SM-1:0] prod_y, prod_z;

	wmcc_pkg::sample_t mean_y_q, mean_z_q;
	wmcc_pkg::sample_t rd_y_s1, rd_z_s1;
	logic              rd_v_s1, first_s1;

	logic signed [DB-1:0] diff_y, diff_z, thr_pos, thr_neg;
	logic                 hi_y, lo_y, hi_z, lo_z;
	logic                 prev_hi_y_q, prev_lo_y_q, prev_hi_z_q, prev_lo_z_q;
	logic                 cross_y, cross_z;

	wmcc_pkg::count_t  cnt_y_q, cnt_z_q;
	wmcc_pkg::sample_t out_mean_y_q, out_mean_z_q;
	wmcc_pkg::count_t  out_cnt_y_q, out_cnt_z_q;

	assign addr = cnt_q[AB-1:0];

	assign sts.cnt_last_win = (cnt_q == wmcc_pkg::CNT_WIN_LAST);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			thr_q    <= wmcc_pkg::THRESH_RESET;
			sum_y_q  <= '0;
			sum_z_q  <= '0;
			rd_v_s1  <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				thr_q <= cfg_write_data;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.accept) begin
				if (sts.cnt_last_win) begin
					sum_y_q <= '0;
					sum_z_q <= '0;
				end else begin
					sum_y_q <= sum_y_nxt;
					sum_z_q <= sum_z_nxt;
				end
			end
			rd_v_s1  <= cmd.walk_rd;
			first_s1 <= cmd.walk_rd && (cnt_q == '0);
		end
	end

	assign sum_y_nxt = sum_y_q + {{(SM-SB){sample_y[SB-1]}}, sample_y};
	assign sum_z_nxt = sum_z_q + {{(SM-SB){sample_z[SB-1]}}, sample_z};

	// store writes and walk reads
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem_y[addr] <= sample_y;
			mem_z[addr] <= sample_z;
		end
		if (cmd.walk_rd) begin
			rd_y_s1 <= mem_y[addr];
			rd_z_s1 <= mem_z[addr];
		end
	end

	// magnitude times rounded-up reciprocal, combinational
	assign prod_y = {{SM{1'b0}}, mag_y_q} * {{SM{1'b0}}, wmcc_pkg::RECIP};
	assign prod_z = {{SM{1'b0}}, mag_z_q} * {{SM{1'b0}}, wmcc_pkg::RECIP};

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.cnt_last_win) begin
			neg_y_q <= sum_y_nxt[SM-1];
			neg_z_q <= sum_z_nxt[SM-1];
			mag_y_q <= sum_y_nxt[SM-1] ? SM'(-sum_y_nxt) : SM'(sum_y_nxt);
			mag_z_q <= sum_z_nxt[SM-1] ? SM'(-sum_z_nxt) : SM'(sum_z_nxt);
		end
		if (cmd.div_step) begin
			quo_y_q <= prod_y[wmcc_pkg::RECIP_SHIFT +: SB];
			quo_z_q <= prod_z[wmcc_pkg::RECIP_SHIFT +: SB];
		end
		if (cmd.mean_latch) begin
			mean_y_q <= neg_y_q ? SB'(-quo_y_q) : quo_y_q;
			mean_z_q <= neg_z_q ? SB'(-quo_z_q) : quo_z_q;
		end
	end

	// crossing classification
	assign thr_pos = {{(DB-TB){1'b0}}, thr_q};
	assign thr_neg = -thr_pos;
	assign diff_y  = {{2{rd_y_s1[SB-1]}}, rd_y_s1} - {{2{mean_y_q[SB-1]}}, mean_y_q};
	assign diff_z  = {{2{rd_z_s1[SB-1]}}, rd_z_s1} - {{2{mean_z_q[SB-1]}}, mean_z_q};
	assign hi_y    = (diff_y > thr_pos);
	assign lo_y    = (diff_y < thr_neg);
	assign hi_z    = (diff_z > thr_pos);
	assign lo_z    = (diff_z < thr_neg);
	assign cross_y = !first_s1 && ((prev_hi_y_q && lo_y) || (prev_lo_y_q && hi_y));
	assign cross_z = !first_s1 && ((prev_hi_z_q && lo_z) || (prev_lo_z_q && hi_z));

	always_ff @(posedge clk) begin
		if (cmd.mean_latch) begin
			cnt_y_q <= '0;
			cnt_z_q <= '0;
		end else if (rd_v_s1) begin
			prev_hi_y_q <= hi_y;
			prev_lo_y_q <= lo_y;
			prev_hi_z_q <= hi_z;
			prev_lo_z_q <= lo_z;
			cnt_y_q     <= cnt_y_q + wmcc_pkg::count_t'(cross_y);
			cnt_z_q     <= cnt_z_q + wmcc_pkg::count_t'(cross_z);
		end
		if (cmd.out_load) begin
			out_mean_y_q <= mean_y_q;
			out_mean_z_q <= mean_z_q;
			out_cnt_y_q  <= cnt_y_q;
			out_cnt_z_q  <= cnt_z_q;
		end
	end

	assign mean_y      = out_mean_y_q;
	assign mean_z      = out_mean_z_q;
	assign crossings_y = out_cnt_y_q;
	assign crossings_z = out_cnt_z_q;

endmodule

>>> sv/windowed_mean_crossing_counter.sv
// ----------------------------------------------------------------------------
// windowed_mean_crossing_counter
// per-axis window mean and threshold-qualified crossing count for Y/Z samples
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall, sample_y, sample_z) takes one Y/Z pair
//   per transaction, one per cycle while a window is loading
//   after the 50th pair the block stalls its input for a reciprocal divide
//   of both sums by the window length, a step to form the means and a
//   walk over the stores (one read port per store, one entry a cycle)
//   result (mean_y, mean_z, crossings_y, crossings_z) appears on out_valid
//   once the walk is done and any earlier result has been taken
//   the result sits in an output register: loading of the next window goes
//   on while it is stalled; only a second finished window waits for it
//   cfg_write_en/cfg_write_data set the crossing threshold (reset 95);
//   write it only while idle
//   reset empties the window, clears sums and drops out_valid
// ----------------------------------------------------------------------------
module windowed_mean_crossing_counter (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write_en,
	input  logic [wmcc_pkg::THRESH_BITS-1:0]        cfg_write_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [wmcc_pkg::SAMPLE_BITS-1:0] sample_y,
	input  logic signed [wmcc_pkg::SAMPLE_BITS-1:0] sample_z,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [wmcc_pkg::SAMPLE_BITS-1:0] mean_y,
	output logic signed [wmcc_pkg::SAMPLE_BITS-1:0] mean_z,
	output logic [wmcc_pkg::COUNT_BITS-1:0]         crossings_y,
	output logic [wmcc_pkg::COUNT_BITS-1:0]         crossings_z
);

	wmcc_pkg::cmd_t cmd;
	wmcc_pkg::sts_t sts;

	wmcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	wmcc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.sample_y       (sample_y),
		.sample_z       (sample_z),
		.mean_y         (mean_y),
		.mean_z         (mean_z),
		.crossings_y    (crossings_y),
		.crossings_z    (crossings_z)
	);

endmodule

>>> sv/wmcc_checker.sv
// ----------------------------------------------------------------------------
// wmcc_checker
// port-level checks for windowed_mean_crossing_counter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wmcc_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write_en,
	input  logic [wmcc_pkg::THRESH_BITS-1:0]        cfg_write_data,
	input  logic                                    in_valid,
	input  logic                                    in_stall,
	input  logic signed [wmcc_pkg::SAMPLE_BITS-1:0] sample_y,
	input  logic signed [wmcc_pkg::SAMPLE_BITS-1:0] sample_z,
	input  logic                                    out_valid,
	input  logic                                    out_stall,
	input  logic signed [wmcc_pkg::SAMPLE_BITS-1:0] mean_y,
	input  logic signed [wmcc_pkg::SAMPLE_BITS-1:0] mean_z,
	input  logic [wmcc_pkg::COUNT_BITS-1:0]         crossings_y,
	input  logic [wmcc_pkg::COUNT_BITS-1:0]         crossings_z
);

	// stalled result transaction holds
	`AST_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(mean_y) && $stable(mean_z)
		&& $stable(crossings_y) && $stable(crossings_z),
		"stalled result changed")

	// a window has one fewer neighbor pair than samples
	`AST_IMPLY(a_cnt_range, out_valid,
		(crossings_y < wmcc_pkg::COUNT_BITS'(wmcc_pkg::WINDOW))
		&& (crossings_z < wmcc_pkg::COUNT_BITS'(wmcc_pkg::WINDOW)),
		"crossing count exceeds window")

	// a new result goes out as the next window starts loading
	`AST_IMPLY(a_load_after_result, $rose(out_valid), !in_stall, "input not open after result")

endmodule

bind windowed_mean_crossing_counter wmcc_checker u_wmcc_checker (.*);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// windowed mean and crossing counter: directed windows, then random windows
// ----------------------------------------------------------------------------
// Directed windows come from a case list. Rows whose result is obvious carry
// a typed summary. All other windows are checked against an in-bench window
// predictor. Random windows mix noise, rail values and swinging signals. The
// crossing threshold is changed only at window boundaries once the block is
// idle. Both channels idle at random. The receiver holds off for one long
// stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 150;
	localparam int SMAX        = (1 << (wmcc_pkg::SAMPLE_BITS - 1)) - 1;
	localparam int SMIN        = -(1 << (wmcc_pkg::SAMPLE_BITS - 1));
	localparam int THMAX       = (1 << wmcc_pkg::THRESH_BITS) - 1;
	localparam int NUM_CASES   = 10;
	localparam int RAND_WINDOWS = 15;
	localparam int TAIL_ITEMS  = 17;

	typedef enum {PAT_CONST, PAT_ALT, PAT_SPLIT, PAT_LEAD} pattern_t;
	typedef enum {AX_NOISE, AX_SWING, AX_EXTREME} axis_mode_t;

	typedef struct {
		wmcc_pkg::sample_t mean_y;
		wmcc_pkg::sample_t mean_z;
		wmcc_pkg::count_t  cross_y;
		wmcc_pkg::count_t  cross_z;
	} summary_t;

	typedef struct {
		pattern_t                         pat;
		logic [wmcc_pkg::THRESH_BITS-1:0] thr;
		int                               base_y;
		int                               amp_y;
		int                               base_z;
		int                               amp_z;
		bit                               known;
		summary_t                         want;
	} window_case_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_write_en = 1'b0;
	logic [wmcc_pkg::THRESH_BITS-1:0] cfg_write_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	wmcc_pkg::sample_t                sample_y = '0;
	wmcc_pkg::sample_t                sample_z = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	wmcc_pkg::sample_t                mean_y;
	wmcc_pkg::sample_t                mean_z;
	wmcc_pkg::count_t                 crossings_y;
	wmcc_pkg::count_t                 crossings_z;

	windowed_mean_crossing_counter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_y       (sample_y),
		.sample_z       (sample_z),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mean_y         (mean_y),
		.mean_z         (mean_z),
		.crossings_y    (crossings_y),
		.crossings_z    (crossings_z)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	wmcc_pkg::sample_t                win_y [wmcc_pkg::WINDOW];
	wmcc_pkg::sample_t                win_z [wmcc_pkg::WINDOW];
	int                               win_fill = 0;
	logic [wmcc_pkg::THRESH_BITS-1:0] model_thr = wmcc_pkg::THRESH_RESET;
	summary_t                         pending_summaries [$];
	window_case_t                     cases [NUM_CASES];
	bit                               use_typed = 1'b0;
	summary_t                         typed_want;
	bit                               sender_burst = 1'b0;
	bit                               hold_off_req = 1'b0;
	int                               error_count = 0;
	int                               summaries_seen = 0;

	function automatic wmcc_pkg::sample_t sat(input int v);
		if (v > SMAX)
			return wmcc_pkg::sample_t'(SMAX);
		if (v < SMIN)
			return wmcc_pkg::sample_t'(SMIN);
		return wmcc_pkg::sample_t'(v);
	endfunction

	function automatic wmcc_pkg::count_t count_swings(input bit axis_z, input int m,
			input int th);
		int n;
		int a;
		int b;
		n = 0;
		for (int i = 0; i + 1 < wmcc_pkg::WINDOW; i++) begin
			a = (axis_z ? int'(win_z[i]) : int'(win_y[i])) - m;
			b = (axis_z ? int'(win_z[i + 1]) : int'(win_y[i + 1])) - m;
			if ((a > th && b < -th) || (a < -th && b > th))
				n++;
		end
		return wmcc_pkg::count_t'(n);
	endfunction

	function automatic summary_t close_window();
		summary_t s;
		int sum_y;
		int sum_z;
		int my;
		int mz;
		sum_y = 0;
		sum_z = 0;
		for (int i = 0; i < wmcc_pkg::WINDOW; i++) begin
			sum_y += int'(win_y[i]);
			sum_z += int'(win_z[i]);
		end
		my = sum_y / wmcc_pkg::WINDOW;
		mz = sum_z / wmcc_pkg::WINDOW;
		s.mean_y  = wmcc_pkg::sample_t'(my);
		s.mean_z  = wmcc_pkg::sample_t'(mz);
		s.cross_y = count_swings(1'b0, my, int'(model_thr));
		s.cross_z = count_swings(1'b1, mz, int'(model_thr));
		return s;
	endfunction

	function automatic summary_t mk_sum(input int my, input int mz, input int cy,
			input int cz);
		summary_t s;
		s.mean_y  = wmcc_pkg::sample_t'(my);
		s.mean_z  = wmcc_pkg::sample_t'(mz);
		s.cross_y = wmcc_pkg::count_t'(cy);
		s.cross_z = wmcc_pkg::count_t'(cz);
		return s;
	endfunction

	function automatic window_case_t mk_case(input pattern_t pat, input int thr,
			input int by, input int ay, input int bz, input int az,
			input bit known, input summary_t want);
		window_case_t c;
		c.pat    = pat;
		c.thr    = wmcc_pkg::THRESH_BITS'(thr);
		c.base_y = by;
		c.amp_y  = ay;
		c.base_z = bz;
		c.amp_z  = az;
		c.known  = known;
		c.want   = want;
		return c;
	endfunction

	function automatic wmcc_pkg::sample_t pattern_sample(input pattern_t pat, input int i,
			input int base, input int amp);
		case (pat)
			PAT_ALT:   return sat((i % 2 == 0) ? base + amp : base - amp);
			PAT_SPLIT: return sat((i < wmcc_pkg::WINDOW / 2) ? base + amp : base - amp);
			PAT_LEAD:  return sat((i == 0) ? base + amp : base);
			default:   return sat(base);
		endcase
	endfunction

	function automatic wmcc_pkg::sample_t axis_sample(input axis_mode_t m, input int base,
			input int amp, input bit hi);
		case (m)
			AX_NOISE:   return wmcc_pkg::sample_t'($urandom);
			AX_EXTREME: return ($urandom_range(0, 1) != 0) ?
				wmcc_pkg::sample_t'(SMAX) : wmcc_pkg::sample_t'(SMIN);
			default:    return sat(base + (hi ? amp : -amp) + int'($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	function automatic axis_mode_t pick_mode();
		int r;
		r = int'($urandom_range(0, 5));
		if (r == 0)
			return AX_NOISE;
		if (r == 1)
			return AX_EXTREME;
		return AX_SWING;
	endfunction

	task automatic take_pair(input wmcc_pkg::sample_t y, input wmcc_pkg::sample_t z);
		win_y[win_fill] = y;
		win_z[win_fill] = z;
		win_fill++;
		if (win_fill == wmcc_pkg::WINDOW) begin
			pending_summaries.push_back(use_typed ? typed_want : close_window());
			win_fill = 0;
		end
	endtask

	task automatic send_pair(input wmcc_pkg::sample_t y, input wmcc_pkg::sample_t z);
		int gap;
		gap = sender_burst ? 0 : int'($urandom_range(0, 15));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_y <= y;
		sample_z <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		take_pair(y, z);
		@(negedge clk);
	endtask

	task automatic write_threshold(input logic [wmcc_pkg::THRESH_BITS-1:0] v);
		in_valid <= 1'b0;
		while (pending_summaries.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		model_thr = v;
	endtask

	task automatic compare_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			error_count++;
		end
	endtask

	task automatic check_summary();
		summary_t want;
		if (pending_summaries.size() == 0) begin
			$error("result transaction with none expected");
			error_count++;
		end else begin
			want = pending_summaries.pop_front();
			compare_field("mean_y", want.mean_y, mean_y);
			compare_field("mean_z", want.mean_z, mean_z);
			compare_field("crossings_y", want.cross_y, crossings_y);
			compare_field("crossings_z", want.cross_z, crossings_z);
		end
		summaries_seen++;
	endtask

	// result side
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				n = 700;
				hold_off_req = 1'b0;
			end else if ((summaries_seen / 4) % 3 == 2) begin
				n = 0;
			end else begin
				n = int'($urandom_range(0, 15));
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			check_summary();
			@(negedge clk);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		axis_mode_t mode_y;
		axis_mode_t mode_z;
		int by;
		int ay;
		int bz;
		int az;
		int flip_pct;
		bit hi_y;
		bit hi_z;
		summary_t none;

		none = mk_sum(0, 0, 0, 0);
		cases[0] = mk_case(PAT_CONST, 95, 0, 0, 0, 0, 1'b1, mk_sum(0, 0, 0, 0));
		cases[1] = mk_case(PAT_CONST, 95, SMAX, 0, SMIN, 0, 1'b1, mk_sum(SMAX, SMIN, 0, 0));
		cases[2] = mk_case(PAT_CONST, 95, SMIN, 0, SMAX, 0, 1'b1, mk_sum(SMIN, SMAX, 0, 0));
		// amplitude one above and exactly at the threshold
		cases[3] = mk_case(PAT_ALT, 95, 0, 96, 0, 95, 1'b1, mk_sum(0, 0, 49, 0));
		cases[4] = mk_case(PAT_ALT, 0, 0, 1, 0, 1, 1'b1, mk_sum(0, 0, 49, 49));
		cases[5] = mk_case(PAT_ALT, THMAX, 0, SMAX, -1, SMAX, 1'b1, mk_sum(0, -1, 0, 0));
		cases[6] = mk_case(PAT_ALT, 0, 0, SMAX, -1, SMAX, 1'b1, mk_sum(0, -1, 49, 49));
		// sums of -1 and 49 truncate to zero
		cases[7] = mk_case(PAT_LEAD, 0, 0, -1, 0, 49, 1'b1, mk_sum(0, 0, 0, 0));
		cases[8] = mk_case(PAT_SPLIT, 200, 100, 1500, -300, 250, 1'b0, none);
		cases[9] = mk_case(PAT_ALT, 1234, 2000, 1300, -2500, 1200, 1'b0, none);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int c = 0; c < NUM_CASES; c++) begin
			if (cases[c].thr != model_thr)
				write_threshold(cases[c].thr);
			use_typed  = cases[c].known;
			typed_want = cases[c].want;
			for (int i = 0; i < wmcc_pkg::WINDOW; i++)
				send_pair(pattern_sample(cases[c].pat, i, cases[c].base_y, cases[c].amp_y),
					pattern_sample(cases[c].pat, i, cases[c].base_z, cases[c].amp_z));
		end
		use_typed = 1'b0;

		for (int w = 0; w < RAND_WINDOWS; w++) begin
			if (w == 0)
				write_threshold(wmcc_pkg::THRESH_BITS'(THMAX));
			else if (w == 5)
				write_threshold('0);
			else if (w % 5 == 0 && !(w >= 8 && w <= 13))
				write_threshold(($urandom_range(0, 3) == 0) ?
					wmcc_pkg::THRESH_BITS'($urandom_range(0, THMAX)) :
					wmcc_pkg::THRESH_BITS'($urandom_range(0, 400)));
			// receiver holds off while full-rate windows keep coming
			if (w == 8)
				hold_off_req = 1'b1;
			sender_burst = (w >= 8 && w < 12) || ($urandom_range(0, 3) == 0);
			mode_y   = pick_mode();
			mode_z   = pick_mode();
			by       = int'($urandom_range(0, 6000)) - 3000;
			bz       = int'($urandom_range(0, 6000)) - 3000;
			ay       = int'($urandom_range(0, 3000));
			az       = int'($urandom_range(0, 3000));
			flip_pct = int'($urandom_range(50, 100));
			hi_y     = 1'($urandom_range(0, 1));
			hi_z     = 1'($urandom_range(0, 1));
			for (int i = 0; i < wmcc_pkg::WINDOW; i++) begin
				if (int'($urandom_range(0, 99)) < flip_pct)
					hi_y = ~hi_y;
				if (int'($urandom_range(0, 99)) < flip_pct)
					hi_z = ~hi_z;
				send_pair(axis_sample(mode_y, by, ay, hi_y), axis_sample(mode_z, bz, az, hi_z));
			end
		end

		// partial window left open at the end
		sender_burst = 1'b0;
		for (int i = 0; i < TAIL_ITEMS; i++)
			send_pair(wmcc_pkg::sample_t'($urandom), wmcc_pkg::sample_t'($urandom));
		in_valid <= 1'b0;

		while (pending_summaries.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
